/* src/soem_pkg.sv */
// Shared types, constants and helpers for the Sobel edge orientation map.
`timescale 1ns / 1ps
package soem_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int CFG_W   = 9;
  localparam int MAG_W   = 11;
  localparam int SQ_W    = 22;
  localparam int GRAD_W  = 12;
  localparam int SUM_W   = CNT_W + 8;
  localparam int BIN_W   = 5;
  localparam logic [BIN_W-1:0] BORDER_BIN = 5'd18;
  localparam logic [BIN_W-1:0] VERT_BIN   = 5'd8;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  function automatic logic [9:0] bin_limit(input logic [2:0] k);
    logic [9:0] v;
    unique case (k)
      3'd0: v = 10'd17;
      3'd1: v = 10'd36;
      3'd2: v = 10'd58;
      3'd3: v = 10'd84;
      3'd4: v = 10'd119;
      3'd5: v = 10'd173;
      3'd6: v = 10'd275;
      default: v = 10'd567;
    endcase
    return v;
  endfunction

  // Datapath commands from the controller.
  typedef struct packed {
    logic store_pixel;   // write pixel word into the frame store
    logic pix_start;     // begin gradient work on the current pixel
    logic scale_start;   // begin scaling of the current pixel
    logic clear_stats;   // reset peak and sum
    logic mean_start;    // begin mean division
    logic drain_start;   // begin scaling for a result
    logic [ADDR_W-1:0] addr;
    logic border;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;          // a multi-cycle operation is under way
  } dp_sts_t;

endpackage

/* src/sobel_edge_orientation_map_core.sv */
// Top level of the Sobel edge orientation map.
`timescale 1ns / 1ps
// Words with tuser 0 load pixels in raster order, one per cycle while no
// result word is stalled on the output. After the last pixel of a frame the
// block computes the frame without accepting words: per interior pixel eight
// store reads, an 11-step square root and up to eight orientation compares,
// per border pixel only the result write, then the scaling divide for each
// pixel, then one mean divide. Each request word (tuser 1) then returns one
// result, computed by the shared bit-serial divider. A request while loading
// returns out_tuser 1 with zero data. A configuration write to index 0 or 1
// restarts loading.
module sobel_edge_orientation_map_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // magnitude, orientation, average, pad
  output logic        out_tuser,  // status
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import soem_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [DIM_W-1:0] width;
  logic [CNT_W-1:0] total;
  logic [7:0] mag, mean;
  logic [BIN_W-1:0] bin;
  logic status;

  soem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .func(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_last(out_tlast), .out_status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index[0]),
    .cfg_hit(cfg_index[7:1] == 7'd0), .cfg_data(cfg_data),
    .width(width), .total(total), .cmd(cmd), .sts(sts)
  );

  soem_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .pixel(in_tdata), .width(width),
    .total(total), .sts(sts), .res_mag(mag), .res_bin(bin), .res_mean(mean)
  );

  assign out_tuser = status;
  assign out_tdata = status ? 24'd0 : {3'b000, mean, bin, mag};
endmodule

/* src/soem_divider.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module soem_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [soem_pkg::SUM_W+1-1:0]  dividend,
  input  logic [soem_pkg::SUM_W+1-1:0]  divisor,
  output logic                          busy,
  output logic [soem_pkg::SUM_W+1-1:0]  quotient
);
  import soem_pkg::*;
  localparam int W = SUM_W + 1;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] q_r, q_nxt, rem_r, rem_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial = {rem_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy = start || (cnt_r != '0);
  assign quotient = q_r;
endmodule

/* src/soem_datapath.sv */
// Frame stores, Sobel gradient, square root, orientation and scaling datapath.
`timescale 1ns / 1ps
module soem_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  soem_pkg::dp_cmd_t               cmd,
  input  logic [7:0]                      pixel,
  input  logic [soem_pkg::DIM_W-1:0]      width,
  input  logic [soem_pkg::CNT_W-1:0]      total,
  output soem_pkg::dp_sts_t               sts,
  output logic [7:0]                      res_mag,
  output logic [soem_pkg::BIN_W-1:0]      res_bin,
  output logic [7:0]                      res_mean
);
  import soem_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FETCH = 10'b0000000010,
    S_GRAD  = 10'b0000000100,
    S_SQR   = 10'b0000001000,
    S_SQRT  = 10'b0000010000,
    S_ORIENT= 10'b0000100000,
    S_WRITE = 10'b0001000000,
    S_RDMAG = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } dp_state_t;

  logic [7:0]       pix_mem [DEPTH];
  logic [MAG_W-1:0] mag_mem [DEPTH];
  logic [BIN_W-1:0] bin_mem [DEPTH];

  dp_state_t st_r, st_nxt;
  logic [3:0] tap_r, tap_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic border_r, drain_r;
  logic [7:0] pix_rd_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [SQ_W-1:0] rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [MAG_W-1:0] mag_r, peak_r, peak_nxt, mag_rd_r;
  logic [BIN_W-1:0] bin_r, bin_nxt, bin_rd_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0] mean_r, scaled_r;
  logic [7:0] scaled_val;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] mag_addr;
  logic mean_pend_r;

  logic div_start;
  logic [SUM_W:0] div_a, div_b, div_q;
  logic div_busy;

  soem_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  assign scaled_val = (peak_r == '0) ? 8'd0 : div_q[7:0];

  // result stores are read at the new address as soon as a start is issued
  assign mag_addr = (st_r == S_IDLE) ? cmd.addr : addr_r;

  // tap offsets: rows -1,0,+1 by cols -1,0,+1, centre skipped (tap 0..7)
  logic signed [1:0] toff_r, toff_c;
  always_comb begin
    unique case (tap_r)
      4'd0: begin toff_r = -2'sd1; toff_c = -2'sd1; end
      4'd1: begin toff_r = -2'sd1; toff_c = 2'sd0; end
      4'd2: begin toff_r = -2'sd1; toff_c = 2'sd1; end
      4'd3: begin toff_r = 2'sd0; toff_c = -2'sd1; end
      4'd4: begin toff_r = 2'sd0; toff_c = 2'sd1; end
      4'd5: begin toff_r = 2'sd1; toff_c = -2'sd1; end
      4'd6: begin toff_r = 2'sd1; toff_c = 2'sd0; end
      default: begin toff_r = 2'sd1; toff_c = 2'sd1; end
    endcase
    rd_addr = addr_r + ADDR_W'({{(ADDR_W-2){toff_r[1]}}, toff_r} * $signed({1'b0, width}))
            + ADDR_W'({{(ADDR_W-2){toff_c[1]}}, toff_c});
  end

  // tap whose read data arrives this cycle is tap_r-1
  logic signed [3:0] wx, wy;
  logic [3:0] ptap;
  always_comb begin
    ptap = tap_r - 4'd1;
    unique case (ptap)
      4'd0: begin wx = -4'sd1; wy = -4'sd1; end
      4'd1: begin wx = 4'sd0; wy = -4'sd2; end
      4'd2: begin wx = 4'sd1; wy = -4'sd1; end
      4'd3: begin wx = -4'sd2; wy = 4'sd0; end
      4'd4: begin wx = 4'sd2; wy = 4'sd0; end
      4'd5: begin wx = -4'sd1; wy = 4'sd1; end
      4'd6: begin wx = 4'sd0; wy = 4'sd2; end
      default: begin wx = 4'sd1; wy = 4'sd1; end
    endcase
  end

  logic [GRAD_W-1:0] ax, ay;
  logic [GRAD_W+9:0] a100, lim_b;
  logic [2:0] k_r, k_nxt;
  logic same_sign;
  logic [SQ_W:0] trial;

  always_comb begin
    ax = gx_r[GRAD_W-1] ? GRAD_W'(-gx_r) : GRAD_W'(gx_r);
    ay = gy_r[GRAD_W-1] ? GRAD_W'(-gy_r) : GRAD_W'(gy_r);
    a100 = (GRAD_W+10)'(ay) * (GRAD_W+10)'(100);
    same_sign = (gy_r == '0) || ((gx_r > 0) == (gy_r > 0));
    lim_b = (GRAD_W+10)'(bin_limit(same_sign ? k_r : 3'd7 - k_r)) * (GRAD_W+10)'(ax);
    trial = {1'b0, rem_r} - {1'b0, root_r + bit_r};
  end

  always_comb begin
    st_nxt = st_r; tap_nxt = tap_r;
    gx_nxt = gx_r; gy_nxt = gy_r;
    rem_nxt = rem_r; root_nxt = root_r; bit_nxt = bit_r;
    bin_nxt = bin_r; k_nxt = k_r; peak_nxt = peak_r; sum_nxt = sum_r;
    div_start = 1'b0;
    div_a = '0; div_b = '0;
    if (cmd.clear_stats) begin
      peak_nxt = '0; sum_nxt = '0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (cmd.pix_start) begin
          if (cmd.border) begin
            st_nxt = S_WRITE;
          end else begin
            st_nxt = S_FETCH; tap_nxt = 4'd0;
          end
          gx_nxt = '0; gy_nxt = '0;
          root_nxt = '0;
        end else if (cmd.scale_start || cmd.drain_start) begin
          st_nxt = S_RDMAG;
        end else if (cmd.mean_start) begin
          div_start = 1'b1;
          div_a = {sum_r, 1'b0} + (SUM_W+1)'(total);
          div_b = (SUM_W+1)'({total, 1'b0});
          st_nxt = S_DIV;
        end
      end
      S_FETCH: begin
        tap_nxt = tap_r + 4'd1;
        st_nxt = S_GRAD;
      end
      S_GRAD: begin
        gx_nxt = gx_r + GRAD_W'(wx * $signed({2'b00, pix_rd_r}));
        gy_nxt = gy_r + GRAD_W'(wy * $signed({2'b00, pix_rd_r}));
        tap_nxt = tap_r + 4'd1;
        if (tap_r == 4'd8) st_nxt = S_SQR;
      end
      S_SQR: begin
        st_nxt = S_SQRT;
        rem_nxt = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        root_nxt = '0;
        bit_nxt = SQ_W'(1) << (SQ_W - 2);
      end
      S_SQRT: begin
        if (bit_r == '0) begin
          st_nxt = S_ORIENT; k_nxt = '0;
          bin_nxt = (gx_r == '0) ? VERT_BIN : (same_sign ? VERT_BIN : 5'd17);
        end else begin
          if (!trial[SQ_W]) begin
            rem_nxt = trial[SQ_W-1:0];
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      S_ORIENT: begin
        if (gx_r == '0) begin
          st_nxt = S_WRITE;
        end else if (same_sign && a100 < lim_b) begin
          bin_nxt = BIN_W'(k_r); st_nxt = S_WRITE;
        end else if (!same_sign && a100 > lim_b) begin
          bin_nxt = 5'd9 + BIN_W'(k_r); st_nxt = S_WRITE;
        end else begin
          k_nxt = k_r + 3'd1;
          if (k_r == 3'd7) st_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!border_r && root_r[MAG_W-1:0] > peak_r) peak_nxt = root_r[MAG_W-1:0];
        st_nxt = S_IDLE;
      end
      S_RDMAG: begin
        st_nxt = S_DIV;
        div_start = 1'b1;
        div_a = (SUM_W+1)'(mag_rd_r) * (SUM_W+1)'(255);
        div_b = (SUM_W+1)'(peak_r);
      end
      S_DIV: begin
        if (!div_busy) st_nxt = S_DONE;
      end
      default: begin
        if (!mean_pend_r && !drain_r) sum_nxt = sum_r + SUM_W'(scaled_val);
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      peak_r <= '0;
      sum_r <= '0;
      mean_r <= '0;
      mean_pend_r <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      peak_r <= peak_nxt;
      sum_r <= sum_nxt;
      if (st_r == S_IDLE && cmd.mean_start) begin
        mean_pend_r <= 1'b1;
      end else if (st_r == S_IDLE && (cmd.scale_start || cmd.drain_start)) begin
        mean_pend_r <= 1'b0;
        drain_r <= cmd.drain_start;
      end
      if (st_r == S_DONE && mean_pend_r) mean_r <= div_q[7:0];
    end
    tap_r <= tap_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt;
    rem_r <= rem_nxt; root_r <= root_nxt; bit_r <= bit_nxt;
    bin_r <= bin_nxt; k_r <= k_nxt;
    if (st_r == S_IDLE && (cmd.pix_start || cmd.scale_start || cmd.drain_start)) begin
      addr_r <= cmd.addr;
      border_r <= cmd.border;
    end
    if (st_r == S_DONE && !mean_pend_r) begin
      scaled_r <= scaled_val;
    end
    if (st_r == S_DONE && drain_r) begin
      // below-average magnitudes report the border bin
      res_bin <= (scaled_val < mean_r) ? BORDER_BIN : bin_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_pixel) pix_mem[cmd.addr] <= pixel;
    pix_rd_r <= pix_mem[rd_addr];
    if (st_r == S_WRITE) begin
      mag_mem[addr_r] <= border_r ? '0 : root_r[MAG_W-1:0];
      bin_mem[addr_r] <= border_r ? BORDER_BIN : bin_r;
    end
    mag_rd_r <= mag_mem[mag_addr];
    bin_rd_r <= bin_mem[mag_addr];
  end

  assign sts.busy = (st_r != S_IDLE);
  assign res_mag = scaled_r;
  assign res_mean = mean_r;
endmodule

/* src/soem_ctrl.sv */
// Controller: load, compute passes, mean and result drain sequencing.
`timescale 1ns / 1ps
module soem_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         func,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic                         out_last,
  output logic                         out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic                         cfg_hit,
  input  logic [soem_pkg::CFG_W-1:0]   cfg_data,
  output logic [soem_pkg::DIM_W-1:0]   width,
  output logic [soem_pkg::CNT_W-1:0]   total,
  output soem_pkg::dp_cmd_t            cmd,
  input  soem_pkg::dp_sts_t            sts
);
  import soem_pkg::*;

  typedef enum logic [6:0] {
    C_LOAD   = 7'b0000001,
    C_PIX    = 7'b0000010,
    C_SCALE  = 7'b0000100,
    C_MEAN   = 7'b0001000,
    C_DRAIN  = 7'b0010000,
    C_RES    = 7'b0100000,
    C_WAIT   = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t st_r, st_nxt;
  logic [DIM_W-1:0] w_r;
  logic [HDIM_W-1:0] h_r;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [COL_W:0] x_r, x_nxt;
  logic [ROW_W:0] y_r, y_nxt;
  logic out_v_r, out_last_r, out_stat_r;
  logic issued_r, issued_nxt;
  logic [CFG_W-1:0] cv;
  logic in_acc, out_free, last_pos, border;

  assign width = w_r;
  assign total = CNT_W'(w_r) * CNT_W'(h_r);
  assign cfg_ready = 1'b1;
  assign out_free = !out_v_r || out_tready;
  assign in_tready = out_free && (st_r == C_LOAD || st_r == C_DRAIN);
  assign in_acc = in_tvalid && in_tready;
  assign last_pos = (pos_r + 1'b1 >= total);
  assign border = (x_r == '0) || (y_r == '0) || (x_r == (COL_W+1)'(w_r - 1'b1))
               || (y_r == (ROW_W+1)'(h_r - 1'b1)) || (w_r < 3) || (h_r < 3);
  assign cv = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; x_nxt = x_r; y_nxt = y_r; issued_nxt = issued_r;
    cmd = '0;
    cmd.addr = pos_r[ADDR_W-1:0];
    cmd.border = border;
    unique case (st_r)
      C_LOAD, C_DRAIN: begin
        if (in_acc && func == FUNC_LOAD) begin
          if (st_r == C_DRAIN) pos_nxt = '0;
          cmd.addr = (st_r == C_DRAIN) ? '0 : pos_r[ADDR_W-1:0];
          cmd.store_pixel = 1'b1;
          pos_nxt = ((st_r == C_DRAIN) ? CNT_W'(0) : pos_r) + 1'b1;
          st_nxt = C_LOAD;
          if (pos_nxt >= total) begin
            st_nxt = C_PIX; pos_nxt = '0; x_nxt = '0; y_nxt = '0;
            issued_nxt = 1'b0; cmd.clear_stats = 1'b1;
          end
        end else if (in_acc && st_r == C_DRAIN) begin
          cmd.drain_start = 1'b1;
          st_nxt = C_RES;
        end
      end
      C_PIX, C_SCALE: begin
        if (!sts.busy) begin
          if (!issued_r) begin
            if (st_r == C_PIX) cmd.pix_start = 1'b1;
            else cmd.scale_start = 1'b1;
            issued_nxt = 1'b1;
          end else begin
            issued_nxt = 1'b0;
            pos_nxt = pos_r + 1'b1;
            if (x_r == (COL_W+1)'(w_r - 1'b1)) begin
              x_nxt = '0; y_nxt = y_r + 1'b1;
            end else begin
              x_nxt = x_r + 1'b1;
            end
            if (last_pos) begin
              pos_nxt = '0; x_nxt = '0; y_nxt = '0;
              st_nxt = (st_r == C_PIX) ? C_SCALE : C_MEAN;
            end
          end
        end
      end
      C_MEAN: begin
        if (!sts.busy) begin
          cmd.mean_start = 1'b1;
          st_nxt = C_WAIT;
        end
      end
      C_WAIT: begin
        if (!sts.busy) st_nxt = C_DRAIN;
      end
      default: begin
        if (!sts.busy) begin
          pos_nxt = pos_r + 1'b1;
          st_nxt = last_pos ? C_LOAD : C_DRAIN;
          if (last_pos) pos_nxt = '0;
        end
      end
    endcase
    if (cfg_valid && cfg_hit) begin
      st_nxt = C_LOAD; pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_LOAD;
      w_r <= DIM_W'(MAX_WIDTH);
      h_r <= HDIM_W'(MAX_HEIGHT);
      pos_r <= '0; x_r <= '0; y_r <= '0;
      issued_r <= 1'b0;
      out_v_r <= 1'b0;
      out_last_r <= 1'b0; out_stat_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; x_r <= x_nxt; y_r <= y_nxt;
      issued_r <= issued_nxt;
      if (cfg_valid && cfg_hit) begin
        if (cfg_index == CFG_IDX_WIDTH)
          w_r <= (cv > CFG_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(cv);
        else
          h_r <= (cv > CFG_W'(MAX_HEIGHT)) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(cv);
      end
      if (in_acc && func == FUNC_REQ && st_r == C_LOAD) begin
        out_v_r <= 1'b1; out_stat_r <= 1'b1; out_last_r <= 1'b0;
      end else if (st_r == C_RES && !sts.busy) begin
        out_v_r <= 1'b1; out_stat_r <= 1'b0; out_last_r <= last_pos;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_last = out_last_r;
  assign out_status = out_stat_r;
endmodule

/* bench/sobel_edge_orientation_map_core_tb.sv */
// Self-checking bench for the Sobel edge orientation map core.
`timescale 1ns / 1ps
module sobel_edge_orientation_map_core_tb;
  import soem_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int CFG_IDX_BOGUS = 255;

  typedef struct {
    logic [7:0] magnitude;
    logic [4:0] orientation;
    logic [7:0] average;
    logic       last;
    logic       status;
  } edge_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = FUNC_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  sobel_edge_orientation_map_core DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  int frame_w, frame_h, load_pos, drain_pos, peak_g, mean_val;
  bit draining;
  int pix_mem[DEPTH];
  int grad_mag[DEPTH];
  int grad_bin[DEPTH];
  int bin_thr[8] = '{17, 36, 58, 84, 119, 173, 275, 567};

  edge_result_t expected_results[$];
  int errors, words_sent, results_seen, frames_done, cycles;
  int send_idle_pct, recv_stall_pct;

  function automatic int isqrt(int n);
    int root, bit_v;
    root = 0;
    bit_v = 1 << 30;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic int orientation_of(int gx, int gy);
    int a, b;
    if (gx == 0) return VERT_BIN;
    a = (gy < 0 ? -gy : gy) * 100;
    b = gx < 0 ? -gx : gx;
    if (gy == 0 || ((gx > 0) == (gy > 0))) begin
      for (int k = 0; k < 8; k++)
        if (a < bin_thr[k] * b) return k;
      return VERT_BIN;
    end
    for (int k = 8; k > 0; k--)
      if (a > bin_thr[k-1] * b) return 9 + (8 - k);
    return 17;
  endfunction

  function automatic int scaled(int g);
    if (peak_g == 0) return 0;
    return (g * 255) / peak_g;
  endfunction

  function automatic void compute_gradients();
    int n, x, y, gx, gy;
    longint sum;
    n = frame_w * frame_h;
    peak_g = 0;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      x = i % frame_w;
      y = i / frame_w;
      if (x == 0 || x == frame_w - 1 || y == 0 || y == frame_h - 1) begin
        grad_mag[i] = 0;
        grad_bin[i] = int'(BORDER_BIN);
      end else begin
        gx = -pix_mem[i-frame_w-1] + pix_mem[i-frame_w+1] - 2*pix_mem[i-1]
             + 2*pix_mem[i+1] - pix_mem[i+frame_w-1] + pix_mem[i+frame_w+1];
        gy = -pix_mem[i-frame_w-1] + pix_mem[i+frame_w-1] - 2*pix_mem[i-frame_w]
             + 2*pix_mem[i+frame_w] - pix_mem[i-frame_w+1] + pix_mem[i+frame_w+1];
        grad_mag[i] = isqrt(gx*gx + gy*gy);
        if (grad_mag[i] > peak_g) peak_g = grad_mag[i];
        grad_bin[i] = orientation_of(gx, gy);
      end
    end
    for (int i = 0; i < n; i++) sum += scaled(grad_mag[i]);
    mean_val = int'((2*sum + n) / (2*longint'(n)));
  endfunction

  function automatic void predict_config(int idx, int val);
    int v;
    v = val & 9'h1FF;
    if (v == 0) v = 1;
    if (idx == CFG_IDX_WIDTH) frame_w = v > MAX_WIDTH ? MAX_WIDTH : v;
    else if (idx == CFG_IDX_HEIGHT) frame_h = v > MAX_HEIGHT ? MAX_HEIGHT : v;
    else return;
    load_pos = 0;
    drain_pos = 0;
    draining = 0;
  endfunction

  function automatic void predict_word(logic func, logic [7:0] pixel);
    edge_result_t r;
    int n, m;
    n = frame_w * frame_h;
    if (func == FUNC_LOAD) begin
      if (draining) begin
        load_pos = 0;
        drain_pos = 0;
        draining = 0;
      end
      pix_mem[load_pos] = int'(pixel);
      load_pos++;
      if (load_pos >= n) begin
        compute_gradients();
        draining = 1;
        drain_pos = 0;
        frames_done++;
      end
      return;
    end
    r = '{default: '0};
    if (!draining) begin
      r.status = 1'b1;
    end else begin
      m = scaled(grad_mag[drain_pos]);
      r.magnitude = 8'(m);
      r.orientation = 5'(m < mean_val ? int'(BORDER_BIN) : grad_bin[drain_pos]);
      r.average = 8'(mean_val);
      r.last = drain_pos + 1 >= n;
      drain_pos++;
      if (drain_pos >= n) begin
        load_pos = 0;
        drain_pos = 0;
        draining = 0;
      end
    end
    expected_results.push_back(r);
  endfunction

  // word sender: valid stays high between back-to-back words
  task automatic send_word(logic func, logic [7:0] pixel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= pixel;
    do @(posedge clk); while (!in_tready);
    predict_word(func, pixel);
    words_sent++;
  endtask

  // a loaded frame may still be in its compute pass
  task automatic settle();
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (draining ? 70 * frame_w * frame_h + 100 : 100) @(posedge clk);
  endtask

  task automatic write_cfg(int idx, int val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= 8'(idx);
    cfg_data <= 9'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    predict_config(idx, val);
  endtask

  task automatic load_frame(int style);
    int n, x, y, v, dx, dy, base;
    n = frame_w * frame_h;
    dx = $urandom_range(80) - 40;
    dy = $urandom_range(80) - 40;
    base = $urandom_range(255);
    for (int i = 0; i < n; i++) begin
      x = i % frame_w;
      y = i / frame_w;
      case (style)
        0: v = $urandom_range(255);
        1: v = base;
        default: begin
          v = base + x*dx + y*dy + $urandom_range(16) - 8;
          v = v < 0 ? 0 : (v > 255 ? 255 : v);
        end
      endcase
      send_word(FUNC_LOAD, 8'(v));
    end
  endtask

  task automatic drain(int count);
    repeat (count) send_word(FUNC_REQ, 8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    edge_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[7:0] !== e.magnitude) begin
          $error("magnitude exp %0d got %0d", e.magnitude, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[12:8] !== e.orientation) begin
          $error("orientation exp %0d got %0d", e.orientation, out_tdata[12:8]);
          errors++;
        end
        if (out_tdata[20:13] !== e.average) begin
          $error("average exp %0d got %0d", e.average, out_tdata[20:13]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_tlast);
          errors++;
        end
        if (out_tuser !== e.status) begin
          $error("status exp %0b got %0b", e.status, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("sobel_edge_orientation_map_core verification failed");
      $finish;
    end
  end

  task automatic test_request_while_loading();
    drain(2);
  endtask

  task automatic test_small_frames();
    write_cfg(CFG_IDX_WIDTH, 3);
    write_cfg(CFG_IDX_HEIGHT, 3);
    // vertical edge, then horizontal edge, then a flat frame
    for (int i = 0; i < 9; i++) send_word(FUNC_LOAD, (i % 3) == 2 ? 8'd255 : 8'd0);
    drain(10);
    for (int i = 0; i < 9; i++) send_word(FUNC_LOAD, i >= 6 ? 8'd255 : 8'd0);
    drain(9);
    load_frame(1);
    drain(9);
  endtask

  task automatic test_load_during_drain();
    load_frame(0);
    drain(3);
    load_frame(2);
    drain(9);
  endtask

  task automatic test_size_extremes();
    write_cfg(CFG_IDX_WIDTH, 0);
    write_cfg(CFG_IDX_HEIGHT, 511);
    load_frame(0);
    drain(4);
    write_cfg(CFG_IDX_BOGUS, 511);
    write_cfg(CFG_IDX_WIDTH, 4);
    write_cfg(CFG_IDX_HEIGHT, 2);
    load_frame(0);
    drain(frame_w * frame_h);
    write_cfg(CFG_IDX_HEIGHT, 1);
    write_cfg(CFG_IDX_WIDTH, 2);
  endtask

  task automatic test_random_frames();
    int target, k;
    target = words_sent + 170;
    k = 0;
    while (words_sent < target) begin
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (k % 3 == 0) begin
        write_cfg(CFG_IDX_WIDTH, $urandom_range(7) + 1);
        write_cfg(CFG_IDX_HEIGHT, $urandom_range(7) + 1);
      end
      if ($urandom_range(9) == 0) drain(1);
      load_frame($urandom_range(9) == 0 ? 1 : ($urandom_range(1) ? 0 : 2));
      if ($urandom_range(7) == 0) drain($urandom_range(frame_w * frame_h - 1));
      else drain(frame_w * frame_h + $urandom_range(1));
      k++;
    end
  endtask

  initial begin
    predict_config(CFG_IDX_WIDTH, 256);
    predict_config(CFG_IDX_HEIGHT, 256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_while_loading();
    test_small_frames();
    test_load_during_drain();
    test_size_extremes();
    test_random_frames();
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d words over %0d frames, checked %0d results;", words_sent,
             frames_done, results_seen);
    $display("frame sizes 1..256 per side, all idle and stall mixes.");
    if (errors == 0) $display("sobel_edge_orientation_map_core verification clean");
    else $display("sobel_edge_orientation_map_core verification failed");
    $finish;
  end

endmodule

/* files.f */
src/soem_pkg.sv
src/soem_divider.sv
src/soem_datapath.sv
src/soem_ctrl.sv
src/sobel_edge_orientation_map_core.sv
bench/sobel_edge_orientation_map_core_tb.sv
